FILE: rtl/core/bresenham_line_pixel_stepper_defines.svh
// ----------------------------------------------------------------------------
// Bresenham line stepper assertion macros
// Concurrent assertion helpers for the line stepper RTL.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line stepper check failed");

// The consequent must hold in the cycle after the antecedent.
`define BLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line stepper check failed");

`endif

FILE: rtl/core/bls_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Panel size, field widths, operation codes and the input item type.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  // Panel geometry.
  localparam int unsigned PanelWidth  = 128;
  localparam int unsigned PanelHeight = 128;

  // Field widths.
  localparam int unsigned CoordW   = 7;
  localparam int unsigned InCoordW = 8;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned ErrW     = 10;

  typedef logic [CoordW-1:0]      coord_t;
  typedef logic [InCoordW-1:0]    in_coord_t;
  typedef logic [ColorW-1:0]      color_t;
  typedef logic signed [ErrW-1:0] err_t;

  // Panel limits at input coordinate width.
  localparam in_coord_t PanelWidthLim  = in_coord_t'(PanelWidth);
  localparam in_coord_t PanelHeightLim = in_coord_t'(PanelHeight);

  typedef enum logic {
    OpStart = 1'b0,
    OpNext  = 1'b1
  } op_e;

  typedef struct packed {
    op_e       op;
    in_coord_t x_start;
    in_coord_t y_start;
    in_coord_t x_end;
    in_coord_t y_end;
    color_t    color;
  } in_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/bls_in_if.sv
// ----------------------------------------------------------------------------
// Line stepper command channel
// Valid/ready channel that carries start and next commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface bls_in_if;
  import bls_pkg::*;

  logic      valid;
  logic      ready;
  logic      op;
  in_coord_t x_start;
  in_coord_t y_start;
  in_coord_t x_end;
  in_coord_t y_end;
  color_t    color;

  modport source (
    output valid, op, x_start, y_start, x_end, y_end, color,
    input  ready
  );

  modport sink (
    input  valid, op, x_start, y_start, x_end, y_end, color,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/bls_out_if.sv
// ----------------------------------------------------------------------------
// Line stepper pixel channel
// Valid/ready channel that carries one pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bls_out_if;
  import bls_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   line_done;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, line_done,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, line_done,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/bls_in_stage.sv
// ----------------------------------------------------------------------------
// Line stepper input register
// Captures one command per transfer and holds it until the core advances.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_in_stage
  import bls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  bls_in_if.sink   in_ch_i,
  input  logic     advance_i,
  output in_item_t item_o,
  output logic     item_valid_o
);

  logic     valid_q;
  in_item_t item_q;
  in_item_t item_d;
  logic     load;

  // The register is free when empty or when its item moves on this cycle.
  assign load          = !valid_q || advance_i;
  assign in_ch_i.ready = load;

  // Pack the channel payload.
  always_comb begin
    item_d.op      = op_e'(in_ch_i.op);
    item_d.x_start = in_ch_i.x_start;
    item_d.y_start = in_ch_i.y_start;
    item_d.x_end   = in_ch_i.x_end;
    item_d.y_end   = in_ch_i.y_end;
    item_d.color   = in_ch_i.color;
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_ch_i.valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (load && in_ch_i.valid) begin
      item_q <= item_d;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/bls_line_core.sv
// ----------------------------------------------------------------------------
// Line stepper core
// Holds the line state, runs setup or one Bresenham step per command and
// registers the resulting pixel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_pixel_stepper_defines.svh"

module bls_line_core
  import bls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  logic     item_valid_i,
  output logic     advance_o,
  bls_out_if.source out_ch_o
);

  localparam int unsigned E2W = ErrW + 1;

  // Line state.
  coord_t cur_x_q, cur_y_q, end_x_q, end_y_q, span_x_q, span_y_q;
  logic   step_x_neg_q, step_y_neg_q, active_q;
  err_t   err_q;
  color_t color_q;

  coord_t cur_x_d, cur_y_d, end_x_d, end_y_d, span_x_d, span_y_d;
  logic   step_x_neg_d, step_y_neg_d, active_d;
  err_t   err_d;
  color_t color_d;

  // Result register.
  logic   out_valid_q;
  coord_t pix_x_q, pix_y_q;
  color_t pix_color_q;
  logic   done_q;

  logic   advance, fire, is_start, reject, emit, done_d;
  coord_t xs, ys, xe, ye;
  logic   x_fwd, y_fwd;
  err_t   span_x_ext, span_y_ext;
  logic signed [E2W-1:0] e2, sx_e2, sy_e2;
  logic   move_x, move_y;

  // The pipeline moves when the result register is empty or being taken.
  assign advance   = !out_valid_q || out_ch_o.ready;
  assign advance_o = advance;
  assign fire      = advance && item_valid_i;
  assign is_start  = (item_i.op == OpStart);

  // Start command decode.
  assign reject = (item_i.x_start >= PanelWidthLim)  || (item_i.x_end >= PanelWidthLim) ||
                  (item_i.y_start >= PanelHeightLim) || (item_i.y_end >= PanelHeightLim);
  assign xs    = item_i.x_start[CoordW-1:0];
  assign ys    = item_i.y_start[CoordW-1:0];
  assign xe    = item_i.x_end[CoordW-1:0];
  assign ye    = item_i.y_end[CoordW-1:0];
  assign x_fwd = xs < xe;
  assign y_fwd = ys < ye;

  // Step decode on the current state, both tests on the same doubled error.
  assign span_x_ext = err_t'({{(ErrW-CoordW){1'b0}}, span_x_q});
  assign span_y_ext = err_t'({{(ErrW-CoordW){1'b0}}, span_y_q});
  assign e2     = {err_q, 1'b0};
  assign sx_e2  = {{(E2W-CoordW){1'b0}}, span_x_q};
  assign sy_e2  = {(E2W){1'b0}} - {{(E2W-CoordW){1'b0}}, span_y_q};
  assign move_x = (e2 >= sy_e2) && (cur_x_q != end_x_q);
  assign move_y = (e2 <= sx_e2) && (cur_y_q != end_y_q);

  // Next state and emit decision.
  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    end_x_d      = end_x_q;
    end_y_d      = end_y_q;
    span_x_d     = span_x_q;
    span_y_d     = span_y_q;
    step_x_neg_d = step_x_neg_q;
    step_y_neg_d = step_y_neg_q;
    err_d        = err_q;
    color_d      = color_q;
    emit         = 1'b0;
    if (is_start) begin
      if (!reject) begin
        emit         = 1'b1;
        cur_x_d      = xs;
        cur_y_d      = ys;
        end_x_d      = xe;
        end_y_d      = ye;
        span_x_d     = x_fwd ? (xe - xs) : (xs - xe);
        span_y_d     = y_fwd ? (ye - ys) : (ys - ye);
        step_x_neg_d = !x_fwd;
        step_y_neg_d = !y_fwd;
        err_d        = err_t'({{(ErrW-CoordW){1'b0}}, span_x_d}) -
                       err_t'({{(ErrW-CoordW){1'b0}}, span_y_d});
        color_d      = item_i.color;
      end
    end else if (active_q) begin
      emit  = 1'b1;
      err_d = err_q - (move_x ? span_y_ext : err_t'(0)) + (move_y ? span_x_ext : err_t'(0));
      if (move_x) begin
        cur_x_d = step_x_neg_q ? (cur_x_q - coord_t'(1)) : (cur_x_q + coord_t'(1));
      end
      if (move_y) begin
        cur_y_d = step_y_neg_q ? (cur_y_q - coord_t'(1)) : (cur_y_q + coord_t'(1));
      end
    end
  end

  assign done_d   = (cur_x_d == end_x_d) && (cur_y_d == end_y_d);
  assign active_d = emit ? !done_d : (is_start ? 1'b0 : active_q);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      span_x_q     <= '0;
      span_y_q     <= '0;
      step_x_neg_q <= 1'b0;
      step_y_neg_q <= 1'b0;
      err_q        <= '0;
      color_q      <= '0;
      active_q     <= 1'b0;
    end else if (fire) begin
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      end_x_q      <= end_x_d;
      end_y_q      <= end_y_d;
      span_x_q     <= span_x_d;
      span_y_q     <= span_y_d;
      step_x_neg_q <= step_x_neg_d;
      step_y_neg_q <= step_y_neg_d;
      err_q        <= err_d;
      color_q      <= color_d;
      active_q     <= active_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= item_valid_i && emit;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      pix_x_q     <= cur_x_d;
      pix_y_q     <= cur_y_d;
      pix_color_q <= color_d;
      done_q      <= done_d;
    end
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.pixel_x     = pix_x_q;
  assign out_ch_o.pixel_y     = pix_y_q;
  assign out_ch_o.pixel_color = pix_color_q;
  assign out_ch_o.line_done   = done_q;

  // A finished line leaves the stepper idle.
  `BLS_ASSERT_NEXT(a_done_goes_idle, fire && emit && done_d, !active_q)
  // A rejected start gives no pixel and leaves the stepper idle.
  `BLS_ASSERT_NEXT(a_reject_idle, fire && is_start && reject, !active_q && !out_valid_q)
  // While a line runs its current point stays inside the panel.
  `BLS_ASSERT_SAME(a_on_panel, active_q,
    ({1'b0, cur_x_q} < PanelWidthLim) && ({1'b0, cur_y_q} < PanelHeightLim))

endmodule

`default_nettype wire

FILE: rtl/core/bresenham_line_pixel_stepper.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel stepper
// Rasterizes one line on the panel: a valid start gives the first pixel, each next one more.
// ----------------------------------------------------------------------------
//  Port      Dir  Transfer carries
//  in_ch_i   in   op, x_start, y_start, x_end, y_end, color
//  out_ch_o  out  pixel_x, pixel_y, pixel_color, line_done
//
// One command per cycle is taken while out_ch_o does not stall; its pixel
// passes through the command register and then the pixel register.
// The step for a command uses the line state left by the previous command,
// updated in the same cycle the pixel register loads.
// rst_ni clears the line state and the valid flags of both registers; the stepper starts idle.
// When out_ch_o stalls, the pixel holds and one more command can be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_pixel_stepper
  import bls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bls_in_if.sink    in_ch_i,
  bls_out_if.source out_ch_o
);

  in_item_t item;
  logic     item_valid;
  logic     advance;

  // Command register.
  bls_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch_i      (in_ch_i),
    .advance_i    (advance),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  // Line state, step logic and pixel register.
  bls_line_core u_line_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .advance_o    (advance),
    .out_ch_o     (out_ch_o)
  );

endmodule

`default_nettype wire

FILE: verif/tb_bresenham_line_pixel_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line pixel stepper testbench
// Sends start and next commands with random gaps and back-pressure, and
// tracks the line state alongside the block. Every pixel transfer is
// compared field by field against the pixel that the tracked line predicts.
// ----------------------------------------------------------------------------

module tb_bresenham_line_pixel_stepper;
  import bls_pkg::*;

  localparam int unsigned PixelTarget = 1800;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned IdlePercent = 25;

  // Tracks the line in progress and holds the pixels still owed by the block.
  class pixel_tracker;
    typedef struct {
      coord_t x;
      coord_t y;
      color_t color;
      logic   done;
    } pixel_t;

    pixel_t      pixels_due[$];
    int unsigned mismatches;

    coord_t cur_x, cur_y, end_x, end_y;
    coord_t span_x, span_y_mag;
    bit     step_x_neg, step_y_neg, active;
    err_t   error_term;
    color_t line_color;

    function new();
      mismatches = 0;
      cur_x = '0; cur_y = '0; end_x = '0; end_y = '0;
      span_x = '0; span_y_mag = '0;
      step_x_neg = 1'b0; step_y_neg = 1'b0; active = 1'b0;
      error_term = '0;
      line_color = '0;
    endfunction

    // Applies one accepted command; returns 1 when a pixel is owed for it.
    function bit take_command(in_item_t cmd);
      pixel_t px;
      int     e2;
      if (cmd.op == OpStart) begin
        if (cmd.x_start >= PanelWidthLim || cmd.y_start >= PanelHeightLim ||
            cmd.x_end >= PanelWidthLim || cmd.y_end >= PanelHeightLim) begin
          active = 1'b0;
          return 1'b0;
        end
        cur_x = coord_t'(cmd.x_start);
        cur_y = coord_t'(cmd.y_start);
        end_x = coord_t'(cmd.x_end);
        end_y = coord_t'(cmd.y_end);
        span_x = (cmd.x_start > cmd.x_end) ? coord_t'(cmd.x_start - cmd.x_end)
                                           : coord_t'(cmd.x_end - cmd.x_start);
        span_y_mag = (cmd.y_start > cmd.y_end) ? coord_t'(cmd.y_start - cmd.y_end)
                                               : coord_t'(cmd.y_end - cmd.y_start);
        step_x_neg = !(cmd.x_start < cmd.x_end);
        step_y_neg = !(cmd.y_start < cmd.y_end);
        error_term = err_t'(int'(span_x) - int'(span_y_mag));
        line_color = cmd.color;
      end else begin
        if (!active) return 1'b0;
        // Both moves are decided on the doubled error taken before either update.
        e2 = 2 * int'(error_term);
        if (e2 >= -int'(span_y_mag) && cur_x != end_x) begin
          error_term = err_t'(int'(error_term) - int'(span_y_mag));
          cur_x = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        if (e2 <= int'(span_x) && cur_y != end_y) begin
          error_term = err_t'(int'(error_term) + int'(span_x));
          cur_y = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
        end
      end
      px.x = cur_x;
      px.y = cur_y;
      px.color = line_color;
      px.done = (cur_x == end_x) && (cur_y == end_y);
      active = !px.done;
      pixels_due.push_back(px);
      return 1'b1;
    endfunction

    // Compares one pixel transfer with the oldest pixel owed.
    function void check_pixel(coord_t x, coord_t y, color_t color, logic done);
      pixel_t px;
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel: x %0d, y %0d, color %h, done %b", x, y, color, done);
        mismatches++;
        return;
      end
      px = pixels_due.pop_front();
      if (x !== px.x) begin
        $error("pixel_x: expected %0d, actual %0d", px.x, x);
        mismatches++;
      end
      if (y !== px.y) begin
        $error("pixel_y: expected %0d, actual %0d", px.y, y);
        mismatches++;
      end
      if (color !== px.color) begin
        $error("pixel_color: expected %h, actual %h", px.color, color);
        mismatches++;
      end
      if (done !== px.done) begin
        $error("line_done: expected %b, actual %b", px.done, done);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bls_in_if  in_ch ();
  bls_out_if out_ch ();

  pixel_tracker tracker;
  bit           steady;
  bit           hold_req;
  bit           hold_done;
  int unsigned  pixels_planned;

  bresenham_line_pixel_stepper i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_bresenham_line_pixel_stepper: errors");
    $finish;
  end

  function automatic in_item_t start_cmd(in_coord_t xs, in_coord_t ys,
                                         in_coord_t xe, in_coord_t ye, color_t color);
    in_item_t cmd;
    cmd.op = OpStart;
    cmd.x_start = xs;
    cmd.y_start = ys;
    cmd.x_end = xe;
    cmd.y_end = ye;
    cmd.color = color;
    return cmd;
  endfunction

  // Next commands carry random payload, which the block must ignore.
  function automatic in_item_t next_cmd();
    in_item_t cmd;
    cmd = start_cmd(in_coord_t'($urandom), in_coord_t'($urandom), in_coord_t'($urandom),
                    in_coord_t'($urandom), color_t'($urandom));
    cmd.op = OpNext;
    return cmd;
  endfunction

  // On-panel coordinate, biased toward the panel edges.
  function automatic in_coord_t pick_coord(int unsigned lim);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return in_coord_t'(lim - 1);
    return in_coord_t'($urandom_range(lim - 1));
  endfunction

  // On-panel coordinate within a dozen of base, for short lines.
  function automatic in_coord_t near_coord(in_coord_t base, int unsigned lim);
    int v;
    v = int'(base) + int'($urandom_range(24)) - 12;
    if (v < 0) v = 0;
    if (v > int'(lim) - 1) v = int'(lim) - 1;
    return in_coord_t'(v);
  endfunction

  // Offers one command, with an optional gap first, and waits for its transfer.
  task automatic send_command(input in_item_t cmd);
    if (!steady && $urandom_range(99) < IdlePercent) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= cmd.op;
    in_ch.x_start <= cmd.x_start;
    in_ch.y_start <= cmd.y_start;
    in_ch.x_end   <= cmd.x_end;
    in_ch.y_end   <= cmd.y_end;
    in_ch.color   <= cmd.color;
    do @(posedge clk_i); while (!in_ch.ready);
    if (tracker.take_command(cmd)) pixels_planned++;
  endtask

  // Random traffic: mostly complete or abandoned lines, some rejected starts
  // and stray next commands.
  task automatic run_random_lines();
    in_item_t    cmd;
    in_coord_t   xs, ys, xe, ye;
    int unsigned kind, steps, dx, dy;
    while (pixels_planned < PixelTarget) begin
      steady = (pixels_planned >= 900 && pixels_planned < 1200);
      if (!hold_done && pixels_planned >= 500) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 6) begin
        // Start with at least one endpoint off the panel.
        cmd = next_cmd();
        cmd.op = OpStart;
        case ($urandom_range(3))
          0: cmd.x_start[InCoordW-1] = 1'b1;
          1: cmd.y_start[InCoordW-1] = 1'b1;
          2: cmd.x_end[InCoordW-1] = 1'b1;
          default: cmd.y_end[InCoordW-1] = 1'b1;
        endcase
        send_command(cmd);
      end else if (kind < 10) begin
        send_command(next_cmd());
      end else begin
        xs = pick_coord(PanelWidth);
        ys = pick_coord(PanelHeight);
        if ($urandom_range(5) == 0) begin
          xe = pick_coord(PanelWidth);
          ye = pick_coord(PanelHeight);
        end else begin
          xe = near_coord(xs, PanelWidth);
          ye = near_coord(ys, PanelHeight);
        end
        send_command(start_cmd(xs, ys, xe, ye, color_t'($urandom)));
        dx = (xs > xe) ? xs - xe : xe - xs;
        dy = (ys > ye) ? ys - ye : ye - ys;
        steps = (dx > dy) ? dx : dy;
        // Now and then the line is cut short by the next start; otherwise
        // it runs to the end, sometimes with a stray next after it.
        if ($urandom_range(9) == 0) steps = $urandom_range(steps);
        else steps += $urandom_range(1);
        repeat (steps) send_command(next_cmd());
      end
    end
  endtask

  // Pixel side: random back-pressure plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_pixel(out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color,
                            out_ch.line_done);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Reset, directed lines, random lines, then drain and report.
  initial begin
    tracker = new();
    steady = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    pixels_planned = 0;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.op      <= OpStart;
    in_ch.x_start <= '0;
    in_ch.y_start <= '0;
    in_ch.x_end   <= '0;
    in_ch.y_end   <= '0;
    in_ch.color   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Next while idle, then one rejection per endpoint field.
    send_command(next_cmd());
    send_command(start_cmd(8'd128, 8'd0, 8'd0, 8'd0, 16'h1234));
    send_command(start_cmd(8'd0, 8'd255, 8'd0, 8'd0, 16'h1234));
    send_command(start_cmd(8'd0, 8'd0, 8'd255, 8'd0, 16'h1234));
    send_command(start_cmd(8'd0, 8'd0, 8'd0, 8'd128, 16'h1234));
    // Single-point line at the far corner, then a next that must give nothing.
    send_command(start_cmd(8'd127, 8'd127, 8'd127, 8'd127, 16'hFFFF));
    send_command(next_cmd());
    // Shallow line run to its end plus one stray next.
    send_command(start_cmd(8'd0, 8'd0, 8'd4, 8'd2, 16'h0000));
    repeat (5) send_command(next_cmd());
    // Steep line stepping left, dropped by a vertical line stepping up.
    send_command(start_cmd(8'd127, 8'd0, 8'd125, 8'd3, 16'h5A5A));
    repeat (2) send_command(next_cmd());
    send_command(start_cmd(8'd0, 8'd127, 8'd0, 8'd124, 16'hA5A5));
    repeat (3) send_command(next_cmd());
    // Horizontal line to the left, then a rejected start while it is active.
    send_command(start_cmd(8'd5, 8'd9, 8'd0, 8'd9, 16'h07E0));
    send_command(next_cmd());
    send_command(start_cmd(8'd200, 8'd10, 8'd12, 8'd12, 16'hF800));
    send_command(next_cmd());

    run_random_lines();
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (tracker.pixels_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("tb_bresenham_line_pixel_stepper: clean");
    end else begin
      $display("tb_bresenham_line_pixel_stepper: errors");
    end
    $finish;
  end

endmodule
